// ===== hw/rtl/hexp_pkg.sv =====
// Package for the hex text parser: parse phase codes, result kind codes,
// character constants, the result queue geometry, the state and result types,
// and the hex digit decoder. No dependencies.
package hexp_pkg;

    // Parse phase codes.
    localparam logic [2:0] PH_START       = 3'd0;
    localparam logic [2:0] PH_ZERO        = 3'd1;
    localparam logic [2:0] PH_ONE         = 3'd2;
    localparam logic [2:0] PH_PREFIX      = 3'd3;
    localparam logic [2:0] PH_AFTER_TOKEN = 3'd4;
    localparam logic [2:0] PH_AFTER_COMMA = 3'd5;

    // Result kind codes.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Characters with a role in the grammar.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    // Result queue geometry.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Parser state carried from one character to the next.
    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] pending;
        logic       err;
    } t_parse_state;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       last_of_run;
    } t_result;

    // Returns {is_digit, value} for one character.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/hexp_if.sv =====
// Stream interfaces of the hex text parser: the character channel and the
// result channel, each with valid/ready. Depends on nothing.
interface hexp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_marker;

    modport source (output valid, output text_char, output end_marker, input ready);
    modport sink   (input valid, input text_char, input end_marker, output ready);
endinterface

interface hexp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       last_of_run;

    modport source (output valid, output kind, output byte_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input byte_value, input last_of_run,
                    output ready);
endinterface

// ===== hw/rtl/hexp_step.sv =====
// Next-state and result logic of the hex text parser for one character.
// Depends on hexp_pkg.
module hexp_step (
    input  hexp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_char,
    input  logic                   i_end,
    output hexp_pkg::t_parse_state o_next,
    output logic [1:0]             o_count,
    output hexp_pkg::t_result      o_res0,
    output hexp_pkg::t_result      o_res1
);
    import hexp_pkg::*;

    logic [4:0]   w_dec;
    logic         w_is_digit;
    logic [3:0]   w_digit;
    t_parse_state w_tok;

    assign w_dec      = hex_decode(i_char);
    assign w_is_digit = w_dec[4];
    assign w_digit    = w_dec[3:0];

    // State after a character that must open a new token.
    always_comb begin
        w_tok = i_state;
        if (!w_is_digit) begin
            w_tok.err = 1'b1;
        end else if (i_char == CH_ZERO) begin
            w_tok.phase   = PH_ZERO;
            w_tok.pending = 4'd0;
        end else begin
            w_tok.phase   = PH_ONE;
            w_tok.pending = w_digit;
        end
    end

    // Main transition and result selection.
    always_comb begin
        o_next  = i_state;
        o_count = 2'd0;
        o_res0  = '0;
        o_res1  = '0;
        if (i_end) begin
            // End of text: flush a one-digit token, then give the status.
            o_next = '{phase: PH_START, pending: 4'd0, err: 1'b0};
            if (!i_state.err && (i_state.phase == PH_ZERO || i_state.phase == PH_ONE)) begin
                o_count = 2'd2;
                o_res0  = '{kind: KIND_BYTE, byte_value: {4'd0, i_state.pending},
                            last_of_run: 1'b0};
                o_res1  = '{kind: KIND_DONE, byte_value: 8'd0, last_of_run: 1'b1};
            end else begin
                o_count = 2'd1;
                if (i_state.err || i_state.phase == PH_PREFIX) begin
                    o_res0 = '{kind: KIND_ERROR, byte_value: 8'd0, last_of_run: 1'b1};
                end else begin
                    o_res0 = '{kind: KIND_DONE, byte_value: 8'd0, last_of_run: 1'b1};
                end
            end
        end else if (!i_state.err) begin
            unique case (i_state.phase)
                PH_START: begin
                    o_next = w_tok;
                end
                PH_ZERO, PH_ONE: begin
                    if (i_state.phase == PH_ZERO && i_char == CH_LOWER_X) begin
                        o_next.phase = PH_PREFIX;
                    end else if (w_is_digit) begin
                        // Second digit completes the token.
                        o_next.phase   = PH_AFTER_TOKEN;
                        o_next.pending = 4'd0;
                        o_count        = 2'd1;
                        o_res0 = '{kind: KIND_BYTE, byte_value: {i_state.pending, w_digit},
                                   last_of_run: 1'b1};
                    end else if (i_char == CH_SPACE || i_char == CH_COMMA) begin
                        // Separator closes a one-digit token.
                        o_next.phase   = (i_char == CH_COMMA) ? PH_AFTER_COMMA
                                                              : PH_AFTER_TOKEN;
                        o_next.pending = 4'd0;
                        o_count        = 2'd1;
                        o_res0 = '{kind: KIND_BYTE, byte_value: {4'd0, i_state.pending},
                                   last_of_run: 1'b1};
                    end else begin
                        o_next.err = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    if (w_is_digit) begin
                        o_next.phase   = PH_ONE;
                        o_next.pending = w_digit;
                    end else begin
                        o_next.err = 1'b1;
                    end
                end
                PH_AFTER_TOKEN: begin
                    if (i_char == CH_COMMA) begin
                        o_next.phase = PH_AFTER_COMMA;
                    end else if (i_char != CH_SPACE) begin
                        o_next = w_tok;
                    end
                end
                PH_AFTER_COMMA: begin
                    if (i_char != CH_SPACE) begin
                        o_next = w_tok;
                    end
                end
                default: begin
                    o_next.err = 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/hex_text_to_bytes_parser.sv =====
// Top level of the hex text parser: parser state registers, per-character
// step logic and the result queue. Depends on hexp_pkg, hexp_if and hexp_step.
//
// The parser takes one character per clock cycle while it is ready and
// turns a text such as "0x1f, 2A 3" into byte results, followed by a done or
// error status when the end marker arrives. The parser state is updated in
// the cycle a character is transferred; its results are written into a
// four-entry result queue and leave it one per cycle while the consumer
// takes them. A character gives at most one result and an end marker at most
// two (a pending one-digit byte and the status); the input is ready while
// fewer than three results are queued, so the queue has room for them.
// After an error status the bytes already delivered for that text are void.
module hex_text_to_bytes_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hexp_in_if.sink           i_in,
    hexp_out_if.source        o_out
);
    import hexp_pkg::*;

    t_parse_state      r_state;
    t_parse_state      n_state;
    logic [1:0]        w_count;
    t_result           w_res0;
    t_result           w_res1;
    t_result           r_queue [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [1:0]        w_push;
    logic              w_in_xfer;
    logic              w_out_xfer;
    t_result           w_head;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;
    assign i_in.ready = (r_count < QCNT_W'(QDEPTH - 1));

    // Parse one character.
    hexp_step u_step (
        .i_state (r_state),
        .i_char  (i_in.text_char),
        .i_end   (i_in.end_marker),
        .o_next  (n_state),
        .o_count (w_count),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    assign w_push = w_in_xfer ? w_count : 2'd0;

    // Parser state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_START, pending: 4'd0, err: 1'b0};
        end else if (w_in_xfer) begin
            r_state <= n_state;
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_queue[r_wr_ptr] <= w_res0;
        end
        if (w_push == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= w_res1;
        end
    end

    // Result queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(w_push);
            if (w_out_xfer) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(w_push) - QCNT_W'(w_out_xfer);
        end
    end

    // Head of the queue drives the output channel.
    assign w_head            = r_queue[r_rd_ptr];
    assign o_out.valid       = (r_count != '0);
    assign o_out.kind        = w_head.kind;
    assign o_out.byte_value  = w_head.byte_value;
    assign o_out.last_of_run = w_head.last_of_run;

endmodule

// ===== hw/rtl/hexp_checker.sv =====
// Port-level checks for the hex text parser, bound to its top level.
// Depends on hexp_pkg and hex_text_to_bytes_parser.
module hexp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_end_marker,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_byte_value,
    input logic       i_out_last_of_run
);
    import hexp_pkg::*;

    // A result held back by the consumer stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transfer");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // After an end marker is taken, a result is always offered in the next cycle.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_end_marker |=> i_out_valid)
        else $error("end marker gave no result");

    // Status results carry a zero byte and close their run.
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_BYTE |->
            i_out_byte_value == 8'd0 && i_out_last_of_run
            && (i_out_kind == KIND_DONE || i_out_kind == KIND_ERROR))
        else $error("malformed status result");

endmodule

bind hex_text_to_bytes_parser hexp_checker u_hexp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_end_marker   (i_in.end_marker),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_kind        (o_out.kind),
    .i_out_byte_value  (o_out.byte_value),
    .i_out_last_of_run (o_out.last_of_run)
);
